### rtl/core/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg: types and constants for the SHA-1 stream hasher
// Item structs, command codes, initial vector and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1s_pkg;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam int unsigned NUM_WORDS = 5;
   localparam logic [2:0]  LAST_WORD = 3'd4;

   localparam logic [7:0]  PAD_MARK   = 8'h80;
   localparam logic [7:0]  PAD_ZERO   = 8'h00;
   localparam logic [5:0]  FILL_LAST  = 6'h3f;
   localparam logic [5:0]  LEN_START  = 6'd56;
   localparam logic [6:0]  LAST_ROUND = 7'd79;

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      logic [31:0] val;
      unique case (idx)
         3'd0:    val = 32'h67452301;
         3'd1:    val = 32'hefcdab89;
         3'd2:    val = 32'h98badcfe;
         3'd3:    val = 32'h10325476;
         default: val = 32'hc3d2e1f0;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] val;
      priority if (rnd < 7'd20) val = 32'h5A827999;
      else if (rnd < 7'd40)     val = 32'h6ED9EBA1;
      else if (rnd < 7'd60)     val = 32'h8F1BBCDC;
      else                      val = 32'hCA62C1D6;
      return val;
   endfunction

   function automatic logic [31:0] round_f(input logic [31:0] b, input logic [31:0] c,
                                           input logic [31:0] d, input logic [6:0] rnd);
      logic [31:0] val;
      priority if (rnd < 7'd20) val = (b & c) | (~b & d);
      else if (rnd < 7'd40)     val = b ^ c ^ d;
      else if (rnd < 7'd60)     val = (b & c) | (b & d) | (c & d);
      else                      val = b ^ c ^ d;
      return val;
   endfunction

endpackage

`default_nettype wire

### rtl/core/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher: SHA-1 digest over a byte stream, one round per cycle
// Absorb shifts one byte in; when it fills a block, 80 rounds and a chain fold follow.
// Finish adds the 0x80 mark, zero padding and the 64-bit bit length, with rounds and a
// fold per filled block, then 5 words at one per cycle while rsp_stall is low.
// Reset clears the byte count and loads the initial vector; the block buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_valid,
   output logic               req_stall,
   input  wire sha1s_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                logic rsp_stall,
   output sha1s_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   state_type   post_ff, post_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic [511:0] block_ff, block_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;
   logic [31:0] work_ff  [sha1s_pkg::NUM_WORDS];
   logic [31:0] work_in  [sha1s_pkg::NUM_WORDS];
   logic [31:0] chain_ff [sha1s_pkg::NUM_WORDS];
   logic [31:0] chain_in [sha1s_pkg::NUM_WORDS];

   logic        shift_en;
   logic [7:0]  shift_byte;
   state_type   after_state;
   logic [63:0] len_bits;
   logic [31:0] w_sum;
   logic [31:0] w_next;
   logic [31:0] t_val;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.digest_word = chain_ff[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last        = (idx_ff == sha1s_pkg::LAST_WORD);

   assign len_bits = {total_ff, 3'b000};

   // schedule window holds w[r..r+15], w[r] at the top
   assign w_sum  = block_ff[95:64] ^ block_ff[255:224] ^ block_ff[447:416] ^ block_ff[511:480];
   assign w_next = {w_sum[30:0], w_sum[31]};
   assign t_val  = {work_ff[0][26:0], work_ff[0][31:27]}
                 + sha1s_pkg::round_f(work_ff[1], work_ff[2], work_ff[3], rnd_ff)
                 + work_ff[4] + sha1s_pkg::round_k(rnd_ff) + block_ff[511:480];

   always_comb begin
      state_in    = state_ff;
      post_in     = post_ff;
      fill_in     = fill_ff;
      total_in    = total_ff;
      block_in    = block_ff;
      rnd_in      = rnd_ff;
      idx_in      = idx_ff;
      work_in     = work_ff;
      chain_in    = chain_ff;
      shift_en    = 1'b0;
      shift_byte  = sha1s_pkg::PAD_ZERO;
      after_state = state_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               shift_en = 1'b1;
               if (req_data.cmd == sha1s_pkg::CMD_FINISH) begin
                  shift_byte  = sha1s_pkg::PAD_MARK;
                  after_state = ST_PAD;
               end else begin
                  shift_byte  = req_data.data_byte;
                  after_state = ST_IDLE;
                  total_in    = total_ff + 61'd1;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == sha1s_pkg::LEN_START) begin
               state_in = ST_LEN;
            end else begin
               shift_en    = 1'b1;
               after_state = ST_PAD;
            end
         end
         ST_LEN: begin
            shift_en    = 1'b1;
            shift_byte  = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
            after_state = (fill_ff == sha1s_pkg::FILL_LAST) ? ST_OUT : ST_LEN;
         end
         ST_ROUND: begin
            work_in[0] = t_val;
            work_in[1] = work_ff[0];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            block_in   = {block_ff[479:0], w_next};
            rnd_in     = rnd_ff + 7'd1;
            if (rnd_ff == sha1s_pkg::LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < sha1s_pkg::NUM_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            idx_in   = 3'd0;
            state_in = post_ff;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == sha1s_pkg::LAST_WORD) begin
                  for (int i = 0; i < sha1s_pkg::NUM_WORDS; i++) begin
                     chain_in[i] = sha1s_pkg::iv_word(3'(i));
                  end
                  total_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // one byte into the block; a full block starts the rounds
      if (shift_en) begin
         block_in = {block_ff[503:0], shift_byte};
         fill_in  = fill_ff + 6'd1;
         if (fill_ff == sha1s_pkg::FILL_LAST) begin
            state_in = ST_ROUND;
            post_in  = after_state;
            rnd_in   = '0;
            work_in  = chain_ff;
         end else begin
            state_in = after_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      rnd_ff   <= rnd_in;
      work_ff  <= work_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         post_ff  <= ST_IDLE;
         fill_ff  <= '0;
         total_ff <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < sha1s_pkg::NUM_WORDS; i++) begin
            chain_ff[i] <= sha1s_pkg::iv_word(3'(i));
         end
      end else begin
         state_ff <= state_in;
         post_ff  <= post_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
   end

endmodule

`default_nettype wire
